FILE: src/id3fp_pkg.sv
// shared types, codes and constants of the id3v2 frame header parser
package id3fp_pkg;

  // known frame ids, first character in the top byte
  localparam logic [31:0] IdArtist = 32'h5450_4531;
  localparam logic [31:0] IdAlbum  = 32'h5441_4C42;
  localparam logic [31:0] IdTitle  = 32'h5449_5432;
  localparam logic [31:0] IdTrack  = 32'h5452_434B;
  localparam logic [31:0] IdImage  = 32'h4150_4943;

  // header layout in bytes
  localparam logic [3:0] HeaderBytes = 4'd10;
  localparam logic [3:0] IdEnd       = 4'd4;
  localparam logic [3:0] SizeEnd     = 4'd8;

  // frame type codes
  localparam logic [2:0] TypeUnknown = 3'd0;
  localparam logic [2:0] TypeArtist  = 3'd1;
  localparam logic [2:0] TypeAlbum   = 3'd2;
  localparam logic [2:0] TypeTitle   = 3'd3;
  localparam logic [2:0] TypeTrack   = 3'd4;
  localparam logic [2:0] TypeImage   = 3'd5;

  // text encoding codes
  localparam logic [2:0] EncLatin1  = 3'd0;
  localparam logic [2:0] EncUtf16Le = 3'd1;
  localparam logic [2:0] EncUtf16Be = 3'd2;
  localparam logic [2:0] EncUtf8    = 3'd3;
  localparam logic [2:0] EncNone    = 3'd4;

  // bytes ahead of the text
  localparam logic [1:0] SkipNone  = 2'd0;
  localparam logic [1:0] SkipPlain = 2'd1;
  localparam logic [1:0] SkipBom   = 2'd3;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [2:0]  frame_type;
    logic [2:0]  text_encoding;
    logic [15:0] header_flags;
    logic [27:0] frame_size;
    logic [1:0]  payload_skip;
    logic [27:0] payload_length;
    logic        length_error;
  } result_t;

  // map a frame id to its type code
  function automatic logic [2:0] classify_id(logic [31:0] id);
    logic [2:0] kind;
    case (id)
      IdArtist: kind = TypeArtist;
      IdAlbum:  kind = TypeAlbum;
      IdTitle:  kind = TypeTitle;
      IdTrack:  kind = TypeTrack;
      IdImage:  kind = TypeImage;
      default:  kind = TypeUnknown;
    endcase
    return kind;
  endfunction

endpackage

FILE: src/id3fp_if.sv
// valid/ready channel interfaces for input bytes and results
interface id3fp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface id3fp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_type;
  logic [2:0]  text_encoding;
  logic [15:0] header_flags;
  logic [27:0] frame_size;
  logic [1:0]  payload_skip;
  logic [27:0] payload_length;
  logic        length_error;

  modport source (output valid, frame_type, text_encoding, header_flags, frame_size,
                  payload_skip, payload_length, length_error, input ready);
  modport sink   (input valid, frame_type, text_encoding, header_flags, frame_size,
                  payload_skip, payload_length, length_error, output ready);
endinterface

FILE: src/id3fp_in_stage.sv
// input register holding one byte beat ahead of the parser
module id3fp_in_stage
  import id3fp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_beat_t beat_i,
  output logic     valid_o,
  input  logic     take_i,
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     accept;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: src/id3fp_parse.sv
// frame header state machine: header collection, encoding byte, payload skip
module id3fp_parse
  import id3fp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     take_o,
  input  logic     res_free_i,
  output logic     res_load_o,
  output result_t  res_o
);

  localparam logic [1:0] PhHeader   = 2'd0;
  localparam logic [1:0] PhEncoding = 2'd1;
  localparam logic [1:0] PhSkip     = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  count_q, count_d;
  logic [31:0] id_q, id_d;
  logic [27:0] size_q, size_d;
  logic [15:0] flags_q, flags_d;
  logic [27:0] remain_q, remain_d;
  logic [2:0]  kind_q, kind_d;

  logic        emit;
  result_t     res;
  logic [1:0]  phase_e;
  logic [3:0]  count_e;
  logic [27:0] remain_e;
  logic [2:0]  kind_e;
  logic [7:0]  b;
  logic [27:0] remain_dec;
  logic [27:0] size_dec;
  logic [2:0]  kind_new;
  logic        fire;

  assign b          = beat_i.data_byte;
  assign remain_dec = remain_e - 28'd1;
  assign size_dec   = size_q - 28'd1;

  // frame start drops any work in progress
  always_comb begin
    phase_e  = phase_q;
    count_e  = count_q;
    remain_e = remain_q;
    kind_e   = kind_q;
    if (beat_i.frame_start) begin
      phase_e  = PhHeader;
      count_e  = '0;
      remain_e = '0;
      kind_e   = TypeUnknown;
    end
  end

  // next state and result for the byte in the input register
  always_comb begin
    phase_d  = phase_e;
    count_d  = count_e;
    id_d     = id_q;
    size_d   = size_q;
    flags_d  = flags_q;
    remain_d = remain_e;
    kind_d   = kind_e;
    kind_new = TypeUnknown;
    emit     = 1'b0;
    res      = '0;
    res.header_flags = flags_q;
    res.frame_size   = size_q;
    res.text_encoding = EncNone;
    case (phase_e)
      PhSkip: begin
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          phase_d = PhHeader;
        end
      end
      PhEncoding: begin
        emit           = 1'b1;
        res.frame_type = kind_e;
        if (b <= 8'd3) begin
          res.text_encoding = b[2:0];
          res.payload_skip  = (b == 8'd1 || b == 8'd2) ? SkipBom : SkipPlain;
          if (size_q < {26'd0, res.payload_skip}) begin
            res.length_error = 1'b1;
          end else begin
            res.payload_length = size_q - {26'd0, res.payload_skip};
          end
        end
        remain_d = size_dec;
        phase_d  = (size_dec == '0) ? PhHeader : PhSkip;
      end
      default: begin
        // header phase, also the unused code
        phase_d = PhHeader;
        if (count_e >= HeaderBytes) begin
          count_d = '0;
        end
        if (count_d == '0) begin
          id_d    = '0;
          size_d  = '0;
          flags_d = '0;
        end
        if (count_d < IdEnd) begin
          id_d = {id_d[23:0], b};
        end else if (count_d < SizeEnd) begin
          size_d = {size_d[20:0], b[6:0]};
        end else begin
          flags_d = {flags_d[7:0], b};
        end
        if (count_d == HeaderBytes - 4'd1) begin
          count_d  = '0;
          kind_new = classify_id(id_d);
          kind_d   = kind_new;
          if (kind_new == TypeUnknown || size_d == '0) begin
            emit             = 1'b1;
            res.frame_type   = kind_new;
            res.header_flags = flags_d;
            res.frame_size   = size_d;
            remain_d         = size_d;
            phase_d          = (size_d == '0) ? PhHeader : PhSkip;
          end else begin
            phase_d = PhEncoding;
          end
        end else begin
          count_d = count_d + 4'd1;
        end
      end
    endcase
  end

  // a byte with a result waits for room in the result register
  assign fire       = valid_i && (!emit || res_free_i);
  assign take_o     = fire;
  assign res_load_o = fire && emit;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      count_q  <= '0;
      id_q     <= '0;
      size_q   <= '0;
      flags_q  <= '0;
      remain_q <= '0;
      kind_q   <= TypeUnknown;
    end else if (fire) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      id_q     <= id_d;
      size_q   <= size_d;
      flags_q  <= flags_d;
      remain_q <= remain_d;
      kind_q   <= kind_d;
    end
  end

  // skip phase always has bytes left to skip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSkip |-> remain_q != '0)
    else $error("skip phase with nothing left");

  // header counter stays inside the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < HeaderBytes)
    else $error("header count out of range");

  // encoding phase only waits on a known, nonempty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhEncoding |-> (kind_q != TypeUnknown && size_q != '0))
    else $error("encoding phase without a known frame");

  // an error result carries no text length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o && res.length_error |-> res.payload_length == '0)
    else $error("length error with nonzero length");

endmodule

FILE: src/id3fp_out_stage.sv
// result register facing the output channel
module id3fp_out_stage
  import id3fp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // room when empty or the held beat leaves now
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || ready_i))
    else $error("result register overrun");

endmodule

FILE: src/id3v2_frame_header_parser_top.sv
// top level of the id3v2 frame header parser
// Takes one byte per cycle with no gaps while the result side keeps up; a byte
// goes from the input register through the frame state logic into the result
// register. A frame gives at most one result: at its last header byte for an
// unknown id or zero size, otherwise at its text-encoding byte. A byte that
// causes a result waits in the input register only while the result register
// is full and not being taken. Payload bytes are counted off and dropped;
// frame_start on a byte restarts header collection at that byte.
module id3v2_frame_header_parser_top
  import id3fp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  id3fp_in_if.sink    in_i,
  id3fp_out_if.source out_o
);

  in_beat_t in_beat, stage_beat;
  logic     stage_valid;
  logic     take;
  logic     res_free;
  logic     res_load;
  result_t  res, res_out;

  assign in_beat.data_byte   = in_i.data_byte;
  assign in_beat.frame_start = in_i.frame_start;

  // input register
  id3fp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .beat_i  (in_beat),
    .valid_o (stage_valid),
    .take_i  (take),
    .beat_o  (stage_beat)
  );

  // frame state and result logic
  id3fp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stage_valid),
    .beat_i     (stage_beat),
    .take_o     (take),
    .res_free_i (res_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  // result register
  id3fp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res),
    .free_o  (res_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res_out)
  );

  assign out_o.frame_type     = res_out.frame_type;
  assign out_o.text_encoding  = res_out.text_encoding;
  assign out_o.header_flags   = res_out.header_flags;
  assign out_o.frame_size     = res_out.frame_size;
  assign out_o.payload_skip   = res_out.payload_skip;
  assign out_o.payload_length = res_out.payload_length;
  assign out_o.length_error   = res_out.length_error;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the id3v2 frame header parser: stimulus, frame model, check
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import id3fp_pkg::*;

  // parse phases of the frame model
  typedef enum logic [1:0] {
    PhHeader   = 2'd0,
    PhEncoding = 2'd1,
    PhSkip     = 2'd2
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  id3fp_in_if  in_if ();
  id3fp_out_if out_if ();

  id3v2_frame_header_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // frame model state
  parse_phase_e phase_q     = PhHeader;
  logic [3:0]   hdr_count_q = '0;
  logic [31:0]  id_q        = '0;
  logic [27:0]  size_q      = '0;
  logic [15:0]  flags_q     = '0;
  logic [27:0]  left_q      = '0;
  logic [2:0]   kind_q      = TypeUnknown;

  result_t frame_results [$];

  logic [31:0] known_ids [5] = '{IdArtist, IdAlbum, IdTitle, IdTrack, IdImage};

  int  bytes_sent    = 0;
  int  results_seen  = 0;
  int  unknown_seen  = 0;
  int  len_err_seen  = 0;
  int  fail_count    = 0;
  int  sink_wait     = 0;
  bit  no_idle       = 1'b0;

  // payload skip start, back to header when nothing is left
  function automatic void start_skip(logic [27:0] n);
    left_q  = n;
    phase_q = (n == 28'd0) ? PhHeader : PhSkip;
  endfunction

  // advance the frame model by one byte, queue the result it gives
  function automatic void parse_byte(logic [7:0] b, logic st);
    result_t r;
    r.frame_type     = kind_q;
    r.text_encoding  = EncNone;
    r.header_flags   = flags_q;
    r.frame_size     = size_q;
    r.payload_skip   = SkipNone;
    r.payload_length = '0;
    r.length_error   = 1'b0;

    if (st) begin
      phase_q     = PhHeader;
      hdr_count_q = '0;
      left_q      = '0;
      kind_q      = TypeUnknown;
    end

    case (phase_q)
      PhSkip: begin
        left_q = left_q - 28'd1;
        if (left_q == 28'd0) phase_q = PhHeader;
      end
      PhEncoding: begin
        r.frame_type   = kind_q;
        r.header_flags = flags_q;
        r.frame_size   = size_q;
        if (b <= 8'd3) begin
          r.text_encoding = b[2:0];
          r.payload_skip  = (b[2:0] == EncUtf16Le || b[2:0] == EncUtf16Be) ? SkipBom : SkipPlain;
          if (size_q < {26'd0, r.payload_skip}) r.length_error = 1'b1;
          else r.payload_length = size_q - {26'd0, r.payload_skip};
        end
        frame_results.push_back(r);
        start_skip(size_q - 28'd1);
      end
      default: begin
        phase_q = PhHeader;
        if (hdr_count_q == 4'd0) begin
          id_q    = '0;
          size_q  = '0;
          flags_q = '0;
        end
        if (hdr_count_q < IdEnd) id_q = {id_q[23:0], b};
        else if (hdr_count_q < SizeEnd) size_q = {size_q[20:0], b[6:0]};
        else flags_q = {flags_q[7:0], b};
        hdr_count_q = hdr_count_q + 4'd1;
        // full header: classify the id
        if (hdr_count_q == HeaderBytes) begin
          hdr_count_q = '0;
          case (id_q)
            IdArtist: kind_q = TypeArtist;
            IdAlbum:  kind_q = TypeAlbum;
            IdTitle:  kind_q = TypeTitle;
            IdTrack:  kind_q = TypeTrack;
            IdImage:  kind_q = TypeImage;
            default:  kind_q = TypeUnknown;
          endcase
          if (kind_q == TypeUnknown || size_q == 28'd0) begin
            r.frame_type   = kind_q;
            r.header_flags = flags_q;
            r.frame_size   = size_q;
            frame_results.push_back(r);
            start_skip(size_q);
          end else begin
            phase_q = PhEncoding;
          end
        end
      end
    endcase
  endfunction

  // one byte beat: random gap, then hold until taken
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.frame_start <= st;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    parse_byte(b, st);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // header (possibly cut short) then the encoding byte and body bytes
  task automatic send_frame(input logic [31:0] id, input logic [27:0] size,
                            input logic [15:0] flags, input logic [7:0] enc,
                            input int hdr_len, input int body, input logic mark);
    logic [7:0] hdr [10];
    for (int k = 0; k < 4; k++) begin
      hdr[k]     = id[8*(3-k) +: 8];
      // bit 7 of a syncsafe byte is noise
      hdr[4 + k] = {1'($urandom_range(0, 1)), 7'(size >> (7 * (3 - k)))};
    end
    hdr[8] = flags[15:8];
    hdr[9] = flags[7:0];
    for (int i = 0; i < hdr_len; i++) send_byte(hdr[i], (i == 0) ? mark : 1'b0);
    for (int i = 0; i < body; i++) send_byte((i == 0) ? enc : 8'($urandom()), 1'b0);
  endtask

  // stop sending until every queued result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (frame_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic void compare_field(string name, logic [27:0] want, logic [27:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result side stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_wait > 0) begin
        out_if.ready <= 1'b0;
        sink_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest queued frame result
  always @(posedge clk_i) begin : check_results
    result_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.frame_type     = out_if.frame_type;
      got.text_encoding  = out_if.text_encoding;
      got.header_flags   = out_if.header_flags;
      got.frame_size     = out_if.frame_size;
      got.payload_skip   = out_if.payload_skip;
      got.payload_length = out_if.payload_length;
      got.length_error   = out_if.length_error;
      if (frame_results.size() == 0) begin
        $error("result with none queued: type %0d size %0h", got.frame_type, got.frame_size);
        fail_count++;
      end else begin
        want = frame_results.pop_front();
        compare_field("frame_type", 28'(want.frame_type), 28'(got.frame_type));
        compare_field("text_encoding", 28'(want.text_encoding), 28'(got.text_encoding));
        compare_field("header_flags", 28'(want.header_flags), 28'(got.header_flags));
        compare_field("frame_size", want.frame_size, got.frame_size);
        compare_field("payload_skip", 28'(want.payload_skip), 28'(got.payload_skip));
        compare_field("payload_length", want.payload_length, got.payload_length);
        compare_field("length_error", 28'(want.length_error), 28'(got.length_error));
        if (want.frame_type == TypeUnknown) unknown_seen++;
        if (want.length_error) len_err_seen++;
      end
      results_seen++;
      sink_wait = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  // each known id with each text encoding, flag extremes
  task automatic test_frame_types();
    logic [15:0] flags;
    for (int i = 0; i < 5; i++) begin
      flags = (i == 0) ? 16'h0000 : (i == 4) ? 16'hFFFF : 16'($urandom());
      send_frame(known_ids[i], 28'(3 + i), flags, 8'(i % 4), 10, 3 + i, 1'(i % 2));
    end
  endtask

  // unknown id, zero size, bad encoding, short utf-16, max size, frame start aborts
  task automatic test_special_cases();
    send_frame(32'h5458_5858, 28'd4, 16'h8040, 8'h00, 10, 4, 1'b1);
    send_frame(IdTitle, 28'd0, 16'hFFFF, 8'h00, 10, 0, 1'b0);
    send_frame(32'h0000_0000, 28'd0, 16'h0000, 8'h00, 10, 0, 1'b0);
    send_frame(IdAlbum, 28'd3, 16'h1234, 8'h04, 10, 3, 1'b0);
    send_frame(IdTrack, 28'd2, 16'hABCD, 8'hFF, 10, 2, 1'b0);
    // utf-16 frames too short for their bom, then a latin-1 frame with no text
    send_frame(IdArtist, 28'd1, 16'h0001, {6'd0, EncUtf16Le[1:0]}, 10, 1, 1'b0);
    send_frame(IdImage, 28'd2, 16'h8000, {6'd0, EncUtf16Be[1:0]}, 10, 2, 1'b0);
    send_frame(IdTitle, 28'd1, 16'h0100, {6'd0, EncLatin1[1:0]}, 10, 1, 1'b0);
    // largest size, skip cut off by a frame start
    send_frame(IdImage, 28'hFFF_FFFF, 16'hFFFF, {6'd0, EncUtf16Be[1:0]}, 10, 5, 1'b0);
    // header cut off by a frame start
    send_frame(IdTrack, 28'd5, 16'h0000, 8'h00, 6, 0, 1'b1);
    // encoding byte replaced by a frame start
    send_frame(IdArtist, 28'd5, 16'h5555, 8'h00, 10, 0, 1'b1);
    send_frame(IdAlbum, 28'd2, 16'hAAAA, {6'd0, EncUtf8[1:0]}, 10, 2, 1'b1);
    wait_drained();
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_stream();
    int          pick, frames, target, body, hdr_len;
    logic [27:0] size;
    logic [31:0] id;
    logic [7:0]  enc;
    logic        need_start;
    bit          drained;
    need_start = 1'b1;
    frames     = 0;
    drained    = 1'b0;
    // byte total for the whole run
    target     = 850;
    while (bytes_sent < target) begin
      if (frames % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (!drained && bytes_sent >= target - 425) begin
        wait_drained();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 3);
      if (pick != 0) id = known_ids[$urandom_range(0, 4)];
      else if ($urandom_range(0, 1) == 0) id = $urandom();
      else id = known_ids[$urandom_range(0, 4)] ^ (32'h1 << $urandom_range(0, 31));
      pick = $urandom_range(0, 9);
      if (pick < 6) size = 28'($urandom_range(0, 12));
      else if (pick < 8) size = 28'($urandom_range(13, 40));
      else if (pick < 9) size = 28'($urandom_range(1, 2));
      else size = 28'd0;
      enc = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(id, size, 16'($urandom()), enc, 10, int'(size),
                   need_start | 1'($urandom_range(0, 1)));
        need_start = 1'b0;
      end else if (pick < 85) begin
        hdr_len = $urandom_range(1, 10);
        body = (hdr_len == 10 && size != 0) ? $urandom_range(0, int'(size) - 1) : 0;
        send_frame(id, size, 16'($urandom()), enc, hdr_len, body, need_start);
        need_start = 1'b1;
      end else if (pick < 92) begin
        size = 28'($urandom_range(64, 32'h0FFF_FFFF));
        send_frame(id, size, 16'($urandom()), enc, 10, $urandom_range(0, 30), need_start);
        need_start = 1'b1;
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom()), ($urandom_range(0, 7) == 0));
        need_start = 1'b1;
      end
      frames++;
    end
    no_idle = 1'b0;
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("id3v2_frame_header_parser_top: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.frame_start = 1'b0;
    rst_ni            = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_frame_types();
    test_special_cases();
    test_random_stream();
    wait_drained();
    $display("sent %0d bytes: all five known ids, unknown ids, zero sizes, bad encodings,",
             bytes_sent);
    $display("  short utf-16 frames and aborted frames; %0d results (%0d unknown, %0d length errors)",
             results_seen, unknown_seen, len_err_seen);
    if (fail_count == 0) begin
      $display("id3v2_frame_header_parser_top: match");
    end else begin
      $display("id3v2_frame_header_parser_top: mismatch");
    end
    $finish;
  end

endmodule
